/* hw/rtl/rcgs_pkg.sv */
package rcgs_pkg;

	// Field widths fixed by the item formats
	localparam int KIND_W  = 3;
	localparam int VALUE_W = 17;
	localparam int LEN_W   = 16;
	localparam int REGIDX_W = 3;
	localparam int CFGDATA_W = 32;

	// Register indexes
	localparam logic [REGIDX_W-1:0] REG_CONF_MASKS   = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_CONF_COUNT   = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_STRUCT_MASKS = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_STRUCT_COUNT = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_SEG_ENABLE   = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_LONG_MIN     = 3'd5;
	localparam logic [REGIDX_W-1:0] REG_OVL_ENABLE   = 3'd6;

	// Metric kinds
	localparam logic [KIND_W-1:0] KIND_CONF_FRAC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RUN_COUNT   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LONGEST     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LONG_FRAC   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STRUCT_FRAC = 3'd4;
	localparam logic [KIND_W-1:0] KIND_OVERLAP     = 3'd5;

	localparam logic [VALUE_W-1:0] FRAC_ONE = 17'd65536;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 17'h1FFFF;

	typedef struct packed {
		logic [1:0] confidence_class;
		logic [2:0] structure_class;
		logic       end_of_protein;
	} residue_t;

	typedef struct packed {
		logic [KIND_W-1:0]  metric_kind;
		logic [1:0]         confidence_group;
		logic [1:0]         structure_group;
		logic [VALUE_W-1:0] metric_value;
		logic [LEN_W-1:0]   protein_length;
		logic               last_metric;
	} metric_t;

	// Configuration snapshot handed from the front to the back
	typedef struct packed {
		logic [15:0] conf_masks;
		logic [2:0]  conf_count;
		logic [31:0] struct_masks;
		logic [2:0]  struct_count;
		logic [3:0]  seg_enable;
		logic [15:0] long_min;
		logic        ovl_enable;
	} cfg_t;

endpackage

/* hw/rtl/rcgs_divider.sv */
// Restoring divider: quotient = floor(num * 2^16 / den), one bit per cycle
module rcgs_divider #(
	parameter int NUM_BITS = 16,
	parameter int DEN_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_BITS-1:0]       num,
	input  logic [DEN_BITS-1:0]       den,
	output logic                      busy,
	output logic                      done,
	output logic [NUM_BITS+16-1:0]    quot
);
	localparam int Q_W = NUM_BITS + 16;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [Q_W-1:0]      dividend_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   diff;

	assign shifted = {rem_q[DEN_BITS-1:0], dividend_q[Q_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign busy    = (cnt_q != '0);
	assign quot    = dividend_q;

	// Count one quotient bit per cycle and pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(Q_W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {num, 16'd0};
			rem_q      <= '0;
			den_q      <= den;
		end else if (busy) begin
			if (!diff[DEN_BITS]) begin
				rem_q      <= diff;
				dividend_q <= {dividend_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q      <= shifted;
				dividend_q <= {dividend_q[Q_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* hw/rtl/rcgs_front.sv */
// Counts group membership and runs per residue, snapshots totals on protein end
module rcgs_front #(
	parameter int CONF_GROUPS   = 4,
	parameter int STRUCT_GROUPS = 4,
	parameter int COUNT_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcgs_pkg::cfg_t       cfg,
	input  logic                 push,
	input  rcgs_pkg::residue_t   in_item,
	output logic                 full,
	// snapshot toward the back
	output logic                 snap_valid,
	input  logic                 snap_taken,
	output rcgs_pkg::cfg_t       snap_cfg,
	output logic [COUNT_BITS-1:0] snap_total,
	output logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_conf,
	output logic [STRUCT_GROUPS-1:0][COUNT_BITS-1:0] snap_struct,
	output logic [CONF_GROUPS*STRUCT_GROUPS-1:0][COUNT_BITS-1:0] snap_ovl,
	output logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_runs,
	output logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_longest,
	output logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_longres
);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam int CG_W = $clog2(CONF_GROUPS + 1);
	localparam int SG_W = $clog2(STRUCT_GROUPS + 1);

	logic [COUNT_BITS-1:0] total_q;
	logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] conf_q, open_q, runs_q, longest_q, longres_q;
	logic [STRUCT_GROUPS-1:0][COUNT_BITS-1:0] struct_q;
	logic [CONF_GROUPS*STRUCT_GROUPS-1:0][COUNT_BITS-1:0] ovl_q;

	logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] conf_n, open_n, runs_n, longest_n, longres_n;
	logic [STRUCT_GROUPS-1:0][COUNT_BITS-1:0] struct_n;
	logic [CONF_GROUPS*STRUCT_GROUPS-1:0][COUNT_BITS-1:0] ovl_n;
	logic [COUNT_BITS-1:0] total_n;
	logic [CONF_GROUPS-1:0] cmem, seg;
	logic [STRUCT_GROUPS-1:0] smem;
	logic [CG_W-1:0] nc;
	logic [SG_W-1:0] ns;
	logic ovl_on, accept;

	assign full   = snap_valid;
	assign accept = push && !full;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CMAX) ? v : v + 1'b1;
	endfunction

	// Clamp the group counts and build membership
	always_comb begin
		nc = (int'(cfg.conf_count) > CONF_GROUPS) ? CG_W'(CONF_GROUPS) : CG_W'(cfg.conf_count);
		ns = (int'(cfg.struct_count) > STRUCT_GROUPS) ? SG_W'(STRUCT_GROUPS)
			: SG_W'(cfg.struct_count);
		for (int p = 0; p < CONF_GROUPS; p++) begin
			cmem[p] = (p < 4) && (p < int'(nc))
				&& cfg.conf_masks[(p % 4) * 4 + int'(in_item.confidence_class)];
			seg[p] = (p < 4) && (p < int'(nc)) && cfg.seg_enable[p % 4];
		end
		for (int d = 0; d < STRUCT_GROUPS; d++)
			smem[d] = (d < 4) && (d < int'(ns))
				&& cfg.struct_masks[(d % 4) * 8 + int'(in_item.structure_class)];
		ovl_on = cfg.ovl_enable && (nc != '0) && (ns != '0);
	end

	// Next counter values for one residue, with runs closed on a non-member residue or at the protein end
	always_comb begin
		logic [COUNT_BITS-1:0] len;
		logic close;
		total_n = sat_inc(total_q);
		for (int p = 0; p < CONF_GROUPS; p++) begin
			conf_n[p]    = cmem[p] ? sat_inc(conf_q[p]) : conf_q[p];
			open_n[p]    = open_q[p];
			runs_n[p]    = runs_q[p];
			longest_n[p] = longest_q[p];
			longres_n[p] = longres_q[p];
			len = open_q[p];
			close = 1'b0;
			if (seg[p]) begin
				if (cmem[p]) open_n[p] = sat_inc(open_q[p]);
				else close = 1'b1;
				if (in_item.end_of_protein) begin
					len = open_n[p];
					close = 1'b1;
				end
			end
			if (close && len != '0) begin
				runs_n[p] = sat_inc(runs_q[p]);
				if (len > longest_q[p]) longest_n[p] = len;
				if (32'(len) >= 32'(cfg.long_min)) begin
					longres_n[p] = ({1'b0, longres_q[p]} + {1'b0, len} > {1'b0, CMAX})
						? CMAX : longres_q[p] + len;
				end
				open_n[p] = '0;
			end
		end
		for (int d = 0; d < STRUCT_GROUPS; d++)
			struct_n[d] = smem[d] ? sat_inc(struct_q[d]) : struct_q[d];
		for (int i = 0; i < CONF_GROUPS * STRUCT_GROUPS; i++)
			ovl_n[i] = (ovl_on && cmem[i / STRUCT_GROUPS] && smem[i % STRUCT_GROUPS])
				? sat_inc(ovl_q[i]) : ovl_q[i];
	end

	// Advance counters; on protein end hand the totals over and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			conf_q     <= '0;
			open_q     <= '0;
			runs_q     <= '0;
			longest_q  <= '0;
			longres_q  <= '0;
			struct_q   <= '0;
			ovl_q      <= '0;
			snap_valid <= 1'b0;
		end else begin
			if (snap_taken) snap_valid <= 1'b0;
			if (accept) begin
				if (in_item.end_of_protein) begin
					total_q   <= '0;
					conf_q    <= '0;
					open_q    <= '0;
					runs_q    <= '0;
					longest_q <= '0;
					longres_q <= '0;
					struct_q  <= '0;
					ovl_q     <= '0;
					snap_valid <= 1'b1;
				end else begin
					total_q   <= total_n;
					conf_q    <= conf_n;
					open_q    <= open_n;
					runs_q    <= runs_n;
					longest_q <= longest_n;
					longres_q <= longres_n;
					struct_q  <= struct_n;
					ovl_q     <= ovl_n;
				end
			end
		end
	end

	// Snapshot payload
	always_ff @(posedge clk) begin
		if (accept && in_item.end_of_protein) begin
			snap_cfg     <= cfg;
			snap_total   <= total_n;
			snap_conf    <= conf_n;
			snap_struct  <= struct_n;
			snap_ovl     <= ovl_n;
			snap_runs    <= runs_n;
			snap_longest <= longest_n;
			snap_longres <= longres_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.end_of_protein) |=> snap_valid && total_q == '0)
		else $error("protein end did not hand over and clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_item.end_of_protein && $past(1'b1)) |=> total_q != '0)
		else $error("residue total lost a residue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(snap_valid && !snap_taken) |=> snap_valid && $stable(snap_total))
		else $error("snapshot dropped before the back took it");

endmodule

/* hw/rtl/rcgs_back.sv */
// Walks the metric list of one snapshot, dividing fractions, into an output queue
module rcgs_back #(
	parameter int CONF_GROUPS   = 4,
	parameter int STRUCT_GROUPS = 4,
	parameter int COUNT_BITS    = 16,
	parameter int FIFO_DEPTH    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 snap_valid,
	output logic                 snap_taken,
	input  rcgs_pkg::cfg_t       snap_cfg,
	input  logic [COUNT_BITS-1:0] snap_total,
	input  logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_conf,
	input  logic [STRUCT_GROUPS-1:0][COUNT_BITS-1:0] snap_struct,
	input  logic [CONF_GROUPS*STRUCT_GROUPS-1:0][COUNT_BITS-1:0] snap_ovl,
	input  logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_runs,
	input  logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_longest,
	input  logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_longres,
	output logic                 empty,
	input  logic                 pop,
	output rcgs_pkg::metric_t    out_item
);
	localparam int CI_W = (CONF_GROUPS > 1) ? $clog2(CONF_GROUPS) : 1;
	localparam int SI_W = (STRUCT_GROUPS > 1) ? $clog2(STRUCT_GROUPS) : 1;
	localparam int CG_W = $clog2(CONF_GROUPS + 1);
	localparam int SG_W = $clog2(STRUCT_GROUPS + 1);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int Q_W = COUNT_BITS + 16;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PICK = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_PUT  = 3'd3;

	logic [2:0]              state_q;
	logic [rcgs_pkg::KIND_W-1:0] kind_q;
	logic [CI_W-1:0]         cg_q;
	logic [SI_W-1:0]         sg_q;
	logic [CG_W-1:0]         nc;
	logic [SG_W-1:0]         ns;
	logic                    ovl_on, seg_cur, is_frac;
	logic [COUNT_BITS-1:0]   operand;
	logic [rcgs_pkg::VALUE_W-1:0] value_q;
	logic [Q_W-1:0]          quot;
	logic                    div_start, div_busy, div_done;
	logic                    is_last, has_next;
	logic [rcgs_pkg::KIND_W-1:0] next_kind;
	logic [CI_W-1:0]         next_cg;
	logic [SI_W-1:0]         next_sg;
	logic                    first_ok;
	logic [rcgs_pkg::KIND_W-1:0] first_kind;

	rcgs_pkg::metric_t       mem_q [FIFO_DEPTH];
	logic [PTR_W:0]          wr_q, rd_q;
	logic                    fifo_full, push_res;
	rcgs_pkg::metric_t       res;

	always_comb begin
		nc = (int'(snap_cfg.conf_count) > CONF_GROUPS) ? CG_W'(CONF_GROUPS)
			: CG_W'(snap_cfg.conf_count);
		ns = (int'(snap_cfg.struct_count) > STRUCT_GROUPS) ? SG_W'(STRUCT_GROUPS)
			: SG_W'(snap_cfg.struct_count);
		ovl_on = snap_cfg.ovl_enable && (nc != '0) && (ns != '0);
		seg_cur = (int'(cg_q) < 4) && snap_cfg.seg_enable[int'(cg_q) % 4];
	end

	// Pick the count for the current metric
	always_comb begin
		is_frac = 1'b1;
		case (kind_q)
			rcgs_pkg::KIND_CONF_FRAC:   operand = snap_conf[cg_q];
			rcgs_pkg::KIND_RUN_COUNT: begin
				operand = snap_runs[cg_q];
				is_frac = 1'b0;
			end
			rcgs_pkg::KIND_LONGEST: begin
				operand = snap_longest[cg_q];
				is_frac = 1'b0;
			end
			rcgs_pkg::KIND_LONG_FRAC:   operand = snap_longres[cg_q];
			rcgs_pkg::KIND_STRUCT_FRAC: operand = snap_struct[sg_q];
			rcgs_pkg::KIND_OVERLAP:     operand = snap_ovl[int'(cg_q) * STRUCT_GROUPS + int'(sg_q)];
			default:                    operand = '0;
		endcase
	end

	// First metric of a snapshot
	always_comb begin
		first_ok = 1'b1;
		first_kind = rcgs_pkg::KIND_CONF_FRAC;
		if (nc == '0) begin
			if (ns != '0) first_kind = rcgs_pkg::KIND_STRUCT_FRAC;
			else first_ok = 1'b0;
		end
	end

	// Step to the metric after the current one
	always_comb begin
		has_next  = 1'b1;
		next_kind = kind_q;
		next_cg   = cg_q;
		next_sg   = sg_q;
		case (kind_q)
			rcgs_pkg::KIND_CONF_FRAC, rcgs_pkg::KIND_LONG_FRAC: begin
				if (kind_q == rcgs_pkg::KIND_CONF_FRAC && seg_cur) begin
					next_kind = rcgs_pkg::KIND_RUN_COUNT;
				end else if (CG_W'(cg_q) + 1'b1 < nc) begin
					next_kind = rcgs_pkg::KIND_CONF_FRAC;
					next_cg   = cg_q + 1'b1;
				end else if (ns != '0) begin
					next_kind = rcgs_pkg::KIND_STRUCT_FRAC;
					next_cg   = '0;
					next_sg   = '0;
				end else begin
					has_next = 1'b0;
				end
			end
			rcgs_pkg::KIND_RUN_COUNT: next_kind = rcgs_pkg::KIND_LONGEST;
			rcgs_pkg::KIND_LONGEST:   next_kind = rcgs_pkg::KIND_LONG_FRAC;
			rcgs_pkg::KIND_STRUCT_FRAC: begin
				if (SG_W'(sg_q) + 1'b1 < ns) begin
					next_sg = sg_q + 1'b1;
				end else if (ovl_on) begin
					next_kind = rcgs_pkg::KIND_OVERLAP;
					next_cg   = '0;
					next_sg   = '0;
				end else begin
					has_next = 1'b0;
				end
			end
			rcgs_pkg::KIND_OVERLAP: begin
				if (SG_W'(sg_q) + 1'b1 < ns) begin
					next_sg = sg_q + 1'b1;
				end else if (CG_W'(cg_q) + 1'b1 < nc) begin
					next_cg = cg_q + 1'b1;
					next_sg = '0;
				end else begin
					has_next = 1'b0;
				end
			end
			default: has_next = 1'b0;
		endcase
		is_last = !has_next;
	end

	assign div_start = (state_q == ST_PICK) && is_frac && (snap_total != '0);

	rcgs_divider #(
		.NUM_BITS(COUNT_BITS),
		.DEN_BITS(COUNT_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (operand),
		.den   (snap_total),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (quot)
	);

	assign fifo_full = (wr_q[PTR_W] != rd_q[PTR_W]) && (wr_q[PTR_W-1:0] == rd_q[PTR_W-1:0]);
	assign empty     = (wr_q == rd_q);
	assign push_res  = (state_q == ST_PUT) && !fifo_full;
	// Release the snapshot after its last metric, or at once when it has none
	assign snap_taken = (push_res && is_last)
		|| ((state_q == ST_IDLE) && snap_valid && !first_ok);

	always_comb begin
		res.metric_kind      = kind_q;
		res.confidence_group = 2'(cg_q);
		res.structure_group  = 2'(sg_q);
		res.metric_value     = value_q;
		res.protein_length   = 16'(snap_total);
		res.last_metric      = is_last;
	end

	// Sequence the metrics of one snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= rcgs_pkg::KIND_CONF_FRAC;
			cg_q    <= '0;
			sg_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (snap_valid && first_ok) begin
						kind_q <= first_kind;
						cg_q   <= '0;
						sg_q   <= '0;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: state_q <= div_start ? ST_DIV : ST_PUT;
				ST_DIV:  if (div_done) state_q <= ST_PUT;
				ST_PUT: begin
					if (push_res) begin
						if (has_next) begin
							kind_q <= next_kind;
							cg_q   <= next_cg;
							sg_q   <= next_sg;
							state_q <= ST_PICK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the metric value
	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			if (!is_frac) value_q <= {1'b0, 16'(operand)};
			else if (snap_total == '0) value_q <= '0;
			else value_q <= '0;
		end else if (div_done) begin
			value_q <= (quot > Q_W'(rcgs_pkg::FRAC_ONE)) ? rcgs_pkg::FRAC_ONE
				: rcgs_pkg::VALUE_W'(quot);
		end
	end

	// Output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push_res) wr_q <= wr_q + 1'b1;
			if (pop && !empty) rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_res) mem_q[wr_q[PTR_W-1:0]] <= res;
	end

	assign out_item = mem_q[rd_q[PTR_W-1:0]];

	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider runs outside the divide step");
	assert property (@(posedge clk) disable iff (!arst_n)
		push_res |-> !fifo_full)
		else $error("result written into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		snap_taken |=> state_q == ST_IDLE)
		else $error("snapshot released before the walk ended");

endmodule

/* hw/rtl/residue_class_group_statistics.sv */
// Residue class group statistics.
// Input queue port: push/full carry one residue (confidence class, structure
// class, end-of-protein mark) per push; one per cycle is taken while full is low.
// Result queue port: empty/pop; the oldest metric sits on the result ports
// while empty is low. Each protein end yields up to 36 metrics, last_metric
// set on the final one; when no groups are in use it yields none.
// Config: cfg_we/cfg_index/cfg_data write a register at once; write only idle.
// Counters update in the cycle a residue is taken. On the last residue the
// totals move to the metric sequencer; counts and lengths pass through its
// pick and put steps, fractions with a nonzero total also through a divide
// step in the one-bit-per-cycle divider. full stays high from the protein
// end until the sequencer has walked all metrics of that protein.
// When pop stalls, the 4-entry result queue fills and the sequencer holds.
// Reset clears all counters and loads register reset values.
module residue_class_group_statistics #(
	parameter int CONF_GROUPS   = 4,
	parameter int STRUCT_GROUPS = 4,
	parameter int COUNT_BITS    = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  rcgs_pkg::residue_t       in_item,
	output logic                     empty,
	input  logic                     pop,
	output rcgs_pkg::metric_t        out_item,
	input  logic                     cfg_we,
	input  logic [rcgs_pkg::REGIDX_W-1:0]  cfg_index,
	input  logic [rcgs_pkg::CFGDATA_W-1:0] cfg_data
);
	rcgs_pkg::cfg_t cfg_q, snap_cfg;
	logic snap_valid, snap_taken;
	logic [COUNT_BITS-1:0] snap_total;
	logic [CONF_GROUPS-1:0][COUNT_BITS-1:0] snap_conf, snap_runs, snap_longest, snap_longres;
	logic [STRUCT_GROUPS-1:0][COUNT_BITS-1:0] snap_struct;
	logic [CONF_GROUPS*STRUCT_GROUPS-1:0][COUNT_BITS-1:0] snap_ovl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_masks   <= 16'd200;
			cfg_q.conf_count   <= 3'd2;
			cfg_q.struct_masks <= 32'd2105025;
			cfg_q.struct_count <= 3'd3;
			cfg_q.seg_enable   <= 4'd1;
			cfg_q.long_min     <= 16'd30;
			cfg_q.ovl_enable   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				rcgs_pkg::REG_CONF_MASKS:   cfg_q.conf_masks   <= cfg_data[15:0];
				rcgs_pkg::REG_CONF_COUNT:   cfg_q.conf_count   <= cfg_data[2:0];
				rcgs_pkg::REG_STRUCT_MASKS: cfg_q.struct_masks <= cfg_data;
				rcgs_pkg::REG_STRUCT_COUNT: cfg_q.struct_count <= cfg_data[2:0];
				rcgs_pkg::REG_SEG_ENABLE:   cfg_q.seg_enable   <= cfg_data[3:0];
				rcgs_pkg::REG_LONG_MIN:     cfg_q.long_min     <= cfg_data[15:0];
				rcgs_pkg::REG_OVL_ENABLE:   cfg_q.ovl_enable   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rcgs_front #(
		.CONF_GROUPS(CONF_GROUPS), .STRUCT_GROUPS(STRUCT_GROUPS), .COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .push(push), .in_item(in_item),
		.full(full), .snap_valid(snap_valid), .snap_taken(snap_taken),
		.snap_cfg(snap_cfg), .snap_total(snap_total), .snap_conf(snap_conf),
		.snap_struct(snap_struct), .snap_ovl(snap_ovl), .snap_runs(snap_runs),
		.snap_longest(snap_longest), .snap_longres(snap_longres)
	);

	rcgs_back #(
		.CONF_GROUPS(CONF_GROUPS), .STRUCT_GROUPS(STRUCT_GROUPS), .COUNT_BITS(COUNT_BITS),
		.FIFO_DEPTH(4)
	) u_back (
		.clk(clk), .arst_n(arst_n), .snap_valid(snap_valid), .snap_taken(snap_taken),
		.snap_cfg(snap_cfg), .snap_total(snap_total), .snap_conf(snap_conf),
		.snap_struct(snap_struct), .snap_ovl(snap_ovl), .snap_runs(snap_runs),
		.snap_longest(snap_longest), .snap_longres(snap_longres),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

endmodule
